/* rtl/header_property_extractor_top_macros.svh */
// Assertion macros for the header property extractor.
// Included by the top level, which carries the concurrent checks; no other dependencies.
`ifndef HEADER_PROPERTY_EXTRACTOR_TOP_MACROS_SVH
`define HEADER_PROPERTY_EXTRACTOR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, sampled on the rising clock edge outside reset.
`define HPE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hpe check failed");
// Next-cycle implication, sampled on the rising clock edge outside reset.
`define HPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hpe check failed");
`else
`define HPE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define HPE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/hpe_pkg.sv */
// Shared types, constants and helpers for the header property extractor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package hpe_pkg;

   // Window depth: the longest property name that can be matched.
   localparam int MAX_NAME_LEN = 16;
   localparam int POS_W        = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;

   // Name characters held by the two 64-bit name registers.
   localparam int NAME_CHARS   = 16;
   localparam int CHAR_IDX_W   = 4;
   localparam int LEN_W        = 5;

   // Configuration port geometry and register indexes.
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 64;
   localparam logic [1:0] REG_NAME_LOW  = 2'd0;
   localparam logic [1:0] REG_NAME_HIGH = 2'd1;
   localparam logic [1:0] REG_NAME_LEN  = 2'd2;

   // Special bytes.
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef logic [NAME_CHARS-1:0][7:0] name_chars_type;

   // One input beat.
   typedef struct packed {
      logic [7:0] header_byte;
      logic       last_byte;
   } hpe_req_type;

   // One result beat.
   typedef struct packed {
      logic       value_valid;
      logic [7:0] value_char;
      logic       verdict_ready;
      logic       found;
   } hpe_rsp_type;

   // Configuration handed from the register file to the cell chain.
   typedef struct packed {
      name_chars_type    name_chars;
      logic [LEN_W-1:0]  eff_len;
   } hpe_cfg_type;

   // ASCII upper-case letters fold to lower case; other bytes are kept.
   function automatic logic [7:0] fold_char(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

   // Name character at an index; characters past the registers read as zero.
   function automatic logic [7:0] name_char(input name_chars_type chars,
                                            input logic [LEN_W-1:0] idx);
      logic [7:0] r;
      r = 8'h00;
      if (idx < LEN_W'(NAME_CHARS)) begin
         r = chars[idx[CHAR_IDX_W-1:0]];
      end
      return r;
   endfunction

endpackage

/* rtl/hpe_csr.sv */
// Configuration registers of the header property extractor, APB-style port.
// Depends on hpe_pkg for register indexes and the configuration struct.
`timescale 1ns / 1ps
module hpe_csr import hpe_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output hpe_cfg_type           cfg
);

   logic [63:0]      name_low_ff;
   logic [63:0]      name_high_ff;
   logic [LEN_W-1:0] name_len_ff;
   logic [1:0]       reg_idx;
   logic             wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:3];
   assign wr_en   = psel && penable && pwrite;

   // Register writes; addresses past the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         name_low_ff  <= '0;
         name_high_ff <= '0;
         name_len_ff  <= LEN_W'(1);
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_NAME_LOW:  name_low_ff  <= pwdata[63:0];
            REG_NAME_HIGH: name_high_ff <= pwdata[63:0];
            REG_NAME_LEN:  name_len_ff  <= pwdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Read mux.
   always_comb begin
      unique case (reg_idx)
         REG_NAME_LOW:  prdata = name_low_ff;
         REG_NAME_HIGH: prdata = name_high_ff;
         REG_NAME_LEN:  prdata = CSR_DATA_W'(name_len_ff);
         default:       prdata = '0;
      endcase
   end

   // Clamp the name length into the range the window supports.
   always_comb begin
      cfg.name_chars = name_chars_type'({name_high_ff, name_low_ff});
      if (name_len_ff == '0) begin
         cfg.eff_len = LEN_W'(1);
      end else if (name_len_ff > LEN_W'(MAX_NAME_LEN)) begin
         cfg.eff_len = LEN_W'(MAX_NAME_LEN);
      end else begin
         cfg.eff_len = name_len_ff;
      end
   end

endmodule

/* rtl/hpe_cell.sv */
// One cell of the byte window chain: holds one recent byte and its valid flag,
// and compares the byte entering it against its name character. Uses hpe_pkg.
`timescale 1ns / 1ps
module hpe_cell import hpe_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift_en,
   input  logic             clear,
   input  logic [POS_W-1:0] position,
   input  hpe_cfg_type      cfg,
   input  logic [7:0]       byte_in,
   input  logic             valid_in,
   output logic [7:0]       byte_out,
   output logic             valid_out,
   output logic             hit
);

   logic [7:0]       byte_ff;
   logic             valid_ff;
   logic             active;
   logic [LEN_W-1:0] char_idx;
   logic [7:0]       expected;

   // A cell beyond the name length always agrees. Cell k (k = 0 newest) is
   // checked against name character eff_len - 1 - k.
   assign active   = LEN_W'(position) < cfg.eff_len;
   assign char_idx = cfg.eff_len - LEN_W'(position) - LEN_W'(1);
   assign expected = name_char(cfg.name_chars, char_idx);
   assign hit      = !active || (valid_in && (fold_char(byte_in) == fold_char(expected)));

   // Byte storage moves one place down the chain per accepted beat in the search phase.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         byte_ff <= byte_in;
      end
   end

   // Valid flag clears at reset and at the end of each header.
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= 1'b0;
      end else if (shift_en) begin
         valid_ff <= valid_in;
      end
   end

   assign byte_out  = byte_ff;
   assign valid_out = valid_ff;

endmodule

/* rtl/hpe_skid.sv */
// Two-entry result buffer: an output register plus a skid register, so the
// block keeps taking beats while a result waits. Uses hpe_pkg for the type.
`timescale 1ns / 1ps
module hpe_skid import hpe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  hpe_rsp_type in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output hpe_rsp_type out_data
);

   logic        out_valid_ff;
   logic        skid_valid_ff;
   hpe_rsp_type out_data_ff;
   hpe_rsp_type skid_data_ff;
   logic        push;
   logic        pop;

   assign in_ready = !skid_valid_ff;
   assign push     = in_valid && in_ready;
   assign pop      = out_valid_ff && out_ready;

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (out_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Payload moves with the flags.
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (push) begin
         if (out_valid_ff && !pop) begin
            skid_data_ff <= in_data;
         end else begin
            out_data_ff <= in_data;
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

/* rtl/header_property_extractor_top.sv */
// Top level of the header property extractor: register file, window cell
// chain, phase controller and result buffer. Uses hpe_pkg and the macro header.
`timescale 1ns / 1ps
//
// Usage:
// Header bytes enter one per beat on the req_ channel (header_byte, plus
// last_byte on the final byte of a header). Every input beat yields exactly
// one result beat on the rsp_ channel: a value byte (value_valid), the single
// verdict of the header (verdict_ready with found), or an all-zero filler.
// The property name is set through the csr_ port: name characters at byte
// addresses 0 and 8, name length at 16; write it while no header is in flight.
// The result of an accepted beat is registered in the result buffer before it reaches
// rsp_; while req_ready is high the block takes one beat per cycle, with a combinational
// compare across the sixteen-cell byte window that shifts one place per searched beat.
// When the receiver stalls, a skid register holds one extra result so one more
// beat is taken; req_ready then drops until rsp_ drains.
// Synchronous reset clears the window, the phase and both result registers,
// and sets the name to empty characters with length one. The final byte of
// every header returns the window and phase to their reset state.
//
`include "header_property_extractor_top_macros.svh"
module header_property_extractor_top import hpe_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  hpe_req_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output hpe_rsp_type           rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam logic [2:0] PH_SEARCH = 3'd0;
   localparam logic [2:0] PH_COLON  = 3'd1;
   localparam logic [2:0] PH_SKIP   = 3'd2;
   localparam logic [2:0] PH_VALUE  = 3'd3;
   localparam logic [2:0] PH_DONE   = 3'd4;

   hpe_cfg_type              cfg;
   logic                     accept;
   logic                     shift_en;
   logic                     clear;
   logic [2:0]               phase_ff;
   logic [2:0]               phase_in;
   hpe_rsp_type              result;
   logic [7:0]               in_byte;
   logic                     in_last;
   logic                     is_term;
   logic                     window_hit;
   logic [MAX_NAME_LEN-1:0]  cell_hit;
   logic [MAX_NAME_LEN:0]    chain_valid;
   logic [7:0]               chain_byte [MAX_NAME_LEN+1];

   assign accept  = req_valid && req_ready;
   assign in_byte = req_data.header_byte;
   assign in_last = req_data.last_byte;
   assign is_term = (in_byte == CHAR_CR) || (in_byte == CHAR_LF);
   assign clear   = accept && in_last;

   // Configuration registers.
   hpe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // Window of recent bytes: cell 0 takes the new byte, each cell hands its
   // byte to the next one on every shift.
   assign chain_byte[0]  = in_byte;
   assign chain_valid[0] = 1'b1;

   for (genvar k = 0; k < MAX_NAME_LEN; k++) begin : g_cell
      hpe_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (shift_en),
         .clear     (clear),
         .position  (POS_W'(k)),
         .cfg       (cfg),
         .byte_in   (chain_byte[k]),
         .valid_in  (chain_valid[k]),
         .byte_out  (chain_byte[k+1]),
         .valid_out (chain_valid[k+1]),
         .hit       (cell_hit[k])
      );
   end

   // The name matches when every cell agrees on the window after this shift.
   assign window_hit = &cell_hit;

   // Phase controller and result of the current beat.
   always_comb begin
      phase_in = phase_ff;
      result   = '0;
      shift_en = 1'b0;
      unique case (phase_ff)
         PH_SEARCH: begin
            shift_en = accept;
            if (window_hit) begin
               phase_in = PH_COLON;
            end
         end
         PH_COLON: begin
            if (in_byte == CHAR_COLON) begin
               phase_in = PH_SKIP;
            end else if (in_byte != CHAR_SPACE) begin
               result.verdict_ready = 1'b1;
               phase_in             = PH_DONE;
            end
         end
         PH_SKIP: begin
            if (is_term) begin
               result.verdict_ready = 1'b1;
               phase_in             = PH_DONE;
            end else if (in_byte != CHAR_SPACE && !in_last) begin
               result.value_valid = 1'b1;
               result.value_char  = in_byte;
               phase_in           = PH_VALUE;
            end
         end
         PH_VALUE: begin
            if (is_term) begin
               result.verdict_ready = 1'b1;
               result.found         = 1'b1;
               phase_in             = PH_DONE;
            end else if (!in_last) begin
               result.value_valid = 1'b1;
               result.value_char  = in_byte;
            end
         end
         PH_DONE: ;
         default: phase_in = PH_DONE;
      endcase

      // An unsettled header ends in a not-found verdict; then start over.
      if (in_last) begin
         if (phase_in != PH_DONE) begin
            result               = '0;
            result.verdict_ready = 1'b1;
         end
         phase_in = PH_SEARCH;
      end

      if (!accept) begin
         phase_in = phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEARCH;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // Result buffer toward the receiver.
   hpe_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_ready  (req_ready),
      .in_data   (result),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   // Once the header is settled, later beats report nothing.
   `HPE_ASSERT_IMPL(a_done_quiet, clock, reset,
                    accept && phase_ff == PH_DONE && !in_last, result == '0)
   // A value byte and the verdict never share one result beat.
   `HPE_ASSERT_IMPL(a_value_or_verdict, clock, reset,
                    accept, !(result.value_valid && result.verdict_ready))
   // The final byte leaves the search phase and an empty window.
   `HPE_ASSERT_NEXT(a_header_restart, clock, reset,
                    clear, phase_ff == PH_SEARCH && !chain_valid[1])
   // Value streaming starts only after the colon and its spaces.
   `HPE_ASSERT_NEXT(a_value_entry, clock, reset,
                    phase_ff != PH_VALUE && phase_ff != PH_SKIP, phase_ff != PH_VALUE)

endmodule

/* tb/header_property_extractor_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for header_property_extractor_top: random header text drives the req_
// channel, and every rsp_ beat is checked against a behavioral scanner. Needs hpe_pkg and the RTL.
module header_property_extractor_top_tb import hpe_pkg::*; ();

   localparam int CYCLE_LIMIT = 200000;

   typedef enum logic [2:0] {
      SEEK_NAME,
      WANT_COLON,
      SKIP_SPACES,
      IN_VALUE,
      SETTLED
   } scan_state_type;

   typedef logic [7:0] text_q_type [$];

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   hpe_req_type           req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   hpe_rsp_type           rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Header beats waiting to be sent and results predicted for accepted beats.
   hpe_req_type   header_beats [$];
   hpe_rsp_type   predicted_rsp [$];
   text_q_type    draft;

   // Scanner copy of the registers and of the per-header state.
   logic [63:0]    name_low_cfg = '0;
   logic [63:0]    name_high_cfg = '0;
   logic [4:0]     name_len_cfg = 5'd1;
   logic [7:0]     recent [MAX_NAME_LEN];
   int             seen_count = 0;
   scan_state_type scan = SEEK_NAME;

   int  error_count = 0;
   int  queued_total = 0;
   int  accepted_beats = 0;
   int  cycle_count = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   bit  calm = 1'b0;

   header_property_extractor_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   // ASCII upper-case letters compare as lower case.
   function automatic logic [7:0] fold_ascii(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
   endfunction

   function automatic int active_name_len();
      int n;
      n = int'(name_len_cfg);
      if (n == 0) begin
         n = 1;
      end
      if (n > MAX_NAME_LEN) begin
         n = MAX_NAME_LEN;
      end
      return n;
   endfunction

   function automatic logic [7:0] cfg_name_char(input int i);
      return (i < 8) ? name_low_cfg[8*i +: 8] : name_high_cfg[8*(i-8) +: 8];
   endfunction

   function automatic void clear_scan();
      for (int i = 0; i < MAX_NAME_LEN; i++) begin
         recent[i] = 8'h00;
      end
      seen_count = 0;
      scan = SEEK_NAME;
   endfunction

   // Advances the scanner by one header byte and returns the result beat it causes.
   function automatic hpe_rsp_type scan_header_byte(input hpe_req_type beat);
      hpe_rsp_type r;
      logic [7:0]  b;
      logic        term;
      int          n;
      bit          hit;
      r = '0;
      b = beat.header_byte;
      term = (b == CHAR_CR) || (b == CHAR_LF);
      case (scan)
         SEEK_NAME: begin
            for (int i = MAX_NAME_LEN - 1; i > 0; i--) begin
               recent[i] = recent[i-1];
            end
            recent[0] = b;
            if (seen_count < MAX_NAME_LEN) begin
               seen_count++;
            end
            n = active_name_len();
            hit = (seen_count >= n);
            for (int i = 0; i < n; i++) begin
               if (fold_ascii(recent[n-1-i]) != fold_ascii(cfg_name_char(i))) begin
                  hit = 1'b0;
               end
            end
            if (hit) begin
               scan = WANT_COLON;
            end
         end
         WANT_COLON: begin
            if (b == CHAR_COLON) begin
               scan = SKIP_SPACES;
            end else if (b != CHAR_SPACE) begin
               r.verdict_ready = 1'b1;
               scan = SETTLED;
            end
         end
         SKIP_SPACES: begin
            if (term) begin
               r.verdict_ready = 1'b1;
               scan = SETTLED;
            end else if (b != CHAR_SPACE && !beat.last_byte) begin
               r.value_valid = 1'b1;
               r.value_char = b;
               scan = IN_VALUE;
            end
         end
         IN_VALUE: begin
            if (term) begin
               r.verdict_ready = 1'b1;
               r.found = 1'b1;
               scan = SETTLED;
            end else if (!beat.last_byte) begin
               r.value_valid = 1'b1;
               r.value_char = b;
            end
         end
         default: begin
            scan = SETTLED;
         end
      endcase
      // The final byte settles an open search as not found and rearms the scanner.
      if (beat.last_byte) begin
         if (scan != SETTLED) begin
            r = '0;
            r.verdict_ready = 1'b1;
         end
         clear_scan();
      end
      return r;
   endfunction

   // Sender: offers queued beats, idling at random unless in a calm phase.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_rsp.push_back(scan_header_byte(req_data));
            accepted_beats++;
         end
         if (!req_valid || req_ready) begin
            if (header_beats.size() != 0 && (calm || $urandom_range(0, 99) >= 15)) begin
               req_valid <= 1'b1;
               req_data <= header_beats.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         error_count++;
      end
   endtask

   // Receiver: checks each result beat, stalls at random and once holds off for a long stretch.
   always @(posedge clock) begin
      hpe_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_rsp.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, actual %h", $time, rsp_data);
               error_count++;
            end else begin
               want = predicted_rsp.pop_front();
               check_field("value_valid", 8'(want.value_valid), 8'(rsp_data.value_valid));
               check_field("value_char", want.value_char, rsp_data.value_char);
               check_field("verdict_ready", 8'(want.verdict_ready),
                           8'(rsp_data.verdict_ready));
               check_field("found", 8'(want.found), 8'(rsp_data.found));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && accepted_beats > 120 && header_beats.size() > 30) begin
            hold_left = 80;
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(0, 99) >= 15);
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // One register write: setup cycle, then access cycle until pready.
   task automatic program_reg(input logic [1:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(idx) << 3;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_NAME_LOW:  name_low_cfg = value;
         REG_NAME_HIGH: name_high_cfg = value;
         REG_NAME_LEN:  name_len_cfg = value[4:0];
         default: ;
      endcase
   endtask

   task automatic program_name(input logic [63:0] low, input logic [63:0] high,
                               input logic [4:0] len);
      program_reg(REG_NAME_LOW, low);
      program_reg(REG_NAME_HIGH, high);
      program_reg(REG_NAME_LEN, 64'(len));
   endtask

   // Turns the draft text into beats, marking its final byte.
   task automatic commit_draft();
      hpe_req_type beat;
      for (int i = 0; i < draft.size(); i++) begin
         beat.header_byte = draft[i];
         beat.last_byte = (i == draft.size() - 1);
         header_beats.push_back(beat);
         queued_total++;
      end
      draft.delete();
   endtask

   task automatic append_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         draft.push_back(s[i]);
      end
   endtask

   // Mostly printable bytes, with a share of arbitrary ones.
   function automatic logic [7:0] noise_byte();
      return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(8'h20, 8'h7E));
   endfunction

   function automatic logic [7:0] name_letter();
      logic [7:0] c;
      c = 8'($urandom_range(8'h61, 8'h7A));
      if ($urandom_range(0, 9) == 0) begin
         c = ($urandom_range(0, 1) == 1) ? 8'h2D : 8'($urandom_range(8'h30, 8'h39));
      end
      return c;
   endfunction

   // One random header: mostly name, colon and value in good order, sometimes broken.
   task automatic queue_random_header();
      logic [7:0] c;
      int         keep;
      repeat ($urandom_range(0, 5)) draft.push_back(noise_byte());
      if ($urandom_range(0, 9) < 8) begin
         for (int i = 0; i < active_name_len(); i++) begin
            c = cfg_name_char(i);
            if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
                && $urandom_range(0, 1) == 1) begin
               c = c ^ 8'h20;
            end
            if ($urandom_range(0, 19) == 0) begin
               c = noise_byte();
            end
            draft.push_back(c);
         end
         repeat ($urandom_range(0, 2)) draft.push_back(CHAR_SPACE);
         draft.push_back(($urandom_range(0, 9) < 9) ? CHAR_COLON : noise_byte());
         repeat ($urandom_range(0, 2)) draft.push_back(CHAR_SPACE);
         repeat ($urandom_range(0, 6)) draft.push_back(noise_byte());
         if ($urandom_range(0, 9) < 8) begin
            draft.push_back(($urandom_range(0, 1) == 1) ? CHAR_CR : CHAR_LF);
         end
         repeat ($urandom_range(0, 3)) draft.push_back(noise_byte());
      end else begin
         repeat ($urandom_range(1, 12)) draft.push_back(noise_byte());
      end
      if (draft.size() == 0) begin
         draft.push_back(noise_byte());
      end
      if ($urandom_range(0, 9) == 0) begin
         keep = $urandom_range(1, draft.size());
         while (draft.size() > keep) begin
            void'(draft.pop_back());
         end
      end
      commit_draft();
   endtask

   // Waits until every beat is sent and every result is back, plus a short tail.
   task automatic wait_idle();
      while (header_beats.size() != 0 || req_valid || predicted_rsp.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic run_random_headers(input int beats);
      int start;
      start = queued_total;
      while (queued_total - start < beats) begin
         queue_random_header();
      end
      wait_idle();
   endtask

   function automatic logic [63:0] random_name_word();
      logic [63:0] w;
      for (int i = 0; i < 8; i++) begin
         w[8*i +: 8] = name_letter();
      end
      return w;
   endfunction

   initial begin
      clear_scan();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset name: a single zero byte.
      run_random_headers(40);

      // Directed headers against the one-letter name K.
      program_name(64'h4B, 64'h0, 5'd1);
      append_text("K");                        // name on the final byte
      commit_draft();
      append_text("aK:");                      // colon on the final byte
      commit_draft();
      append_text("k :v");                     // found, then a byte after the verdict
      draft.push_back(CHAR_CR);
      draft.push_back(CHAR_LF);
      commit_draft();
      append_text("Kx");                       // wrong byte after the name
      commit_draft();
      append_text("K: ");                      // terminator before any value byte
      draft.push_back(CHAR_LF);
      commit_draft();
      append_text("K:ab");                     // final byte is a value byte
      commit_draft();
      draft.push_back(8'hFF);
      draft.push_back(8'h00);
      commit_draft();
      wait_idle();

      // A zero length counts as one character.
      program_reg(REG_NAME_LEN, 64'd0);
      run_random_headers(50);

      // Longest name, in a phase with no idling on either side.
      program_name(random_name_word(), random_name_word(), 5'd16);
      calm = 1'b1;
      run_random_headers(55);
      calm = 1'b0;

      // Length above the window clamps to sixteen; all-ones characters in the low word.
      program_name(64'hFFFF_FFFF_FFFF_FFFF, random_name_word(), 5'd31);
      run_random_headers(55);

      // Random names and lengths.
      repeat (4) begin
         program_name(random_name_word(), random_name_word(), 5'($urandom_range(1, 16)));
         run_random_headers(55);
      end

      repeat (8) @(posedge clock);
      if (error_count == 0 && predicted_rsp.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
